/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/rpt_pkg.sv */
package rpt_pkg;

  localparam int CP_W        = 21;
  localparam int KIND_W      = 4;
  localparam int BODY_W      = 3;
  localparam int POS_W       = 4;
  localparam int QUEUE_DEPTH = 4;

  typedef logic [CP_W-1:0]   cp_t;
  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [BODY_W-1:0] body_t;
  typedef logic [POS_W-1:0]  pos_t;

  localparam kind_t KIND_SYM   = 4'd0;
  localparam kind_t KIND_OPEN  = 4'd1;
  localparam kind_t KIND_CLOSE = 4'd2;
  localparam kind_t KIND_STAR  = 4'd3;
  localparam kind_t KIND_PLUS  = 4'd4;
  localparam kind_t KIND_OPT   = 4'd5;
  localparam kind_t KIND_UNION = 4'd6;
  localparam kind_t KIND_END   = 4'd7;
  localparam kind_t KIND_ERR   = 4'd8;

  // token run shapes
  localparam body_t BODY_NONE   = 3'd0;
  localparam body_t BODY_ONE    = 3'd1;
  localparam body_t BODY_NDIGIT = 3'd2;
  localparam body_t BODY_SPACE  = 3'd3;
  localparam body_t BODY_NSPACE = 3'd4;
  localparam body_t BODY_WORD   = 3'd5;
  localparam body_t BODY_NWORD  = 3'd6;

  localparam cp_t CH_LPAR  = 21'h28;
  localparam cp_t CH_RPAR  = 21'h29;
  localparam cp_t CH_STAR  = 21'h2A;
  localparam cp_t CH_PLUS  = 21'h2B;
  localparam cp_t CH_DOT   = 21'h2E;
  localparam cp_t CH_QMARK = 21'h3F;
  localparam cp_t CH_BSL   = 21'h5C;
  localparam cp_t CH_BAR   = 21'h7C;
  localparam cp_t CH_LO_D  = 21'h64;
  localparam cp_t CH_UP_D  = 21'h44;
  localparam cp_t CH_LO_S  = 21'h73;
  localparam cp_t CH_UP_S  = 21'h53;
  localparam cp_t CH_LO_W  = 21'h77;
  localparam cp_t CH_UP_W  = 21'h57;
  localparam cp_t CH_LO_N  = 21'h6E;
  localparam cp_t CH_LO_F  = 21'h66;
  localparam cp_t CH_LO_R  = 21'h72;
  localparam cp_t CH_LO_T  = 21'h74;
  localparam cp_t CH_LO_V  = 21'h76;

  typedef struct packed {
    kind_t kind;
    cp_t   lo;
    cp_t   hi;
  } tok_t;

  typedef struct packed {
    body_t body;
    tok_t  one;
    logic  has_end;
  } desc_t;

  function automatic pos_t body_len(input body_t body);
    pos_t len;
    unique case (body)
      BODY_ONE:    len = 4'd1;
      BODY_NDIGIT: len = 4'd5;
      BODY_SPACE:  len = 4'd5;
      BODY_NSPACE: len = 4'd7;
      BODY_WORD:   len = 4'd9;
      BODY_NWORD:  len = 4'd11;
      default:     len = 4'd0;
    endcase
    return len;
  endfunction

  function automatic tok_t sym(input logic [7:0] lo, input logic [7:0] hi);
    tok_t t;
    t.kind = KIND_SYM;
    t.lo   = {13'd0, lo};
    t.hi   = {13'd0, hi};
    return t;
  endfunction

  // k-th byte range of a class union
  function automatic tok_t class_range(input body_t body, input logic [2:0] k);
    tok_t t;
    t = sym(8'h00, 8'h00);
    unique case (body)
      BODY_NDIGIT: begin
        if (k == 3'd0) t = sym(8'h00, 8'h2F);
        else           t = sym(8'h3A, 8'hFF);
      end
      BODY_SPACE: begin
        if (k == 3'd0) t = sym(8'h09, 8'h0D);
        else           t = sym(8'h20, 8'h20);
      end
      BODY_NSPACE: begin
        unique case (k)
          3'd0:    t = sym(8'h00, 8'h08);
          3'd1:    t = sym(8'h0E, 8'h1F);
          default: t = sym(8'h21, 8'hFF);
        endcase
      end
      BODY_WORD: begin
        unique case (k)
          3'd0:    t = sym(8'h30, 8'h39);
          3'd1:    t = sym(8'h41, 8'h5A);
          3'd2:    t = sym(8'h5F, 8'h5F);
          default: t = sym(8'h61, 8'h7A);
        endcase
      end
      BODY_NWORD: begin
        unique case (k)
          3'd0:    t = sym(8'h00, 8'h2F);
          3'd1:    t = sym(8'h3A, 8'h40);
          3'd2:    t = sym(8'h5B, 8'h5E);
          3'd3:    t = sym(8'h60, 8'h60);
          default: t = sym(8'h7B, 8'hFF);
        endcase
      end
      default: t = sym(8'h00, 8'h00);
    endcase
    return t;
  endfunction

  // token at position idx of a descriptor body
  function automatic tok_t body_tok(input desc_t d, input pos_t idx);
    tok_t t;
    pos_t len;
    len = body_len(d.body);
    priority if (d.body == BODY_ONE) begin
      t = d.one;
    end else if (idx == 4'd0) begin
      t.kind = KIND_OPEN;
      t.lo   = CH_LPAR;
      t.hi   = CH_LPAR;
    end else if (idx == len - 4'd1) begin
      t.kind = KIND_CLOSE;
      t.lo   = CH_RPAR;
      t.hi   = CH_RPAR;
    end else if (idx[0]) begin
      t = class_range(d.body, idx[3:1]);
    end else begin
      t.kind = KIND_UNION;
      t.lo   = CH_BAR;
      t.hi   = CH_BAR;
    end
    return t;
  endfunction

endpackage

/* src/rpt_channels.sv */
interface rpt_in_if;
  logic             valid;
  logic             ready;
  rpt_pkg::cp_t     code_point;
  logic             is_last;

  modport source (output valid, output code_point, output is_last, input ready);
  modport sink   (input valid, input code_point, input is_last, output ready);
endinterface

interface rpt_out_if;
  logic             valid;
  logic             ready;
  rpt_pkg::kind_t   token_kind;
  rpt_pkg::cp_t     range_low;
  rpt_pkg::cp_t     range_high;
  logic             last_of_run;

  modport source (output valid, output token_kind, output range_low, output range_high,
                  output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input range_low, input range_high,
                  input last_of_run, output ready);
endinterface

/* src/regex_pattern_tokenizer_core.sv */
// Regular expression tokenizer: one code point is taken per transfer on in_ch and the tokens it
// causes leave on out_ch, one token per cycle as out_ch allows, with last_of_run marking the
// final token of each item. A classifier accepts one code point every cycle until the queue
// fills and writes a run descriptor into a QUEUE_DEPTH-entry queue; the token generator expands
// each descriptor at one token per cycle into a registered output. Ordinary characters,
// operators and simple escapes give one token (two with the end token); items without an end
// token flow at one per cycle. A class escape holds the generator for 5 to 11 tokens (12 with
// an end token) while the input keeps accepting. A backslash that is not last yields no token.
module regex_pattern_tokenizer_core #(
  parameter int QUEUE_DEPTH = rpt_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  rpt_in_if.sink     in_ch,
  rpt_out_if.source  out_ch
);

  logic           q_push;
  logic           q_push_ready;
  rpt_pkg::desc_t q_push_desc;
  logic           q_pop;
  logic           q_valid;
  rpt_pkg::desc_t q_head;

  rpt_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_push  (q_push),
    .q_desc  (q_push_desc),
    .q_ready (q_push_ready)
  );

  rpt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_desc  (q_push_desc),
    .push_ready (q_push_ready),
    .pop        (q_pop),
    .head_desc  (q_head),
    .head_valid (q_valid)
  );

  rpt_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_desc  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

/* src/rpt_front.sv */
`include "assert_macros.svh"

module rpt_front (
  input  logic           clk,
  input  logic           rst_n,
  rpt_in_if.sink         in_ch,
  output logic           q_push,
  output rpt_pkg::desc_t q_desc,
  input  logic           q_ready
);

  logic           esc_r;
  logic           esc_nxt;
  logic           in_xfer;
  rpt_pkg::cp_t   c;
  rpt_pkg::desc_t d;
  logic           esc_set;

  assign c            = in_ch.code_point;
  assign in_ch.ready  = q_ready;
  assign in_xfer      = in_ch.valid && q_ready;

  always_comb begin
    d.body     = rpt_pkg::BODY_ONE;
    d.one.kind = rpt_pkg::KIND_SYM;
    d.one.lo   = c;
    d.one.hi   = c;
    d.has_end  = in_ch.is_last;
    esc_set    = 1'b0;
    if (esc_r) begin
      unique case (c)
        rpt_pkg::CH_LPAR, rpt_pkg::CH_RPAR, rpt_pkg::CH_STAR, rpt_pkg::CH_PLUS,
        rpt_pkg::CH_QMARK, rpt_pkg::CH_BAR, rpt_pkg::CH_BSL, rpt_pkg::CH_DOT: begin
          d.one.kind = rpt_pkg::KIND_SYM;
        end
        rpt_pkg::CH_LO_D: begin
          d.one.lo = 21'h30;
          d.one.hi = 21'h39;
        end
        rpt_pkg::CH_UP_D: d.body = rpt_pkg::BODY_NDIGIT;
        rpt_pkg::CH_LO_S: d.body = rpt_pkg::BODY_SPACE;
        rpt_pkg::CH_UP_S: d.body = rpt_pkg::BODY_NSPACE;
        rpt_pkg::CH_LO_W: d.body = rpt_pkg::BODY_WORD;
        rpt_pkg::CH_UP_W: d.body = rpt_pkg::BODY_NWORD;
        rpt_pkg::CH_LO_N: begin
          d.one.lo = 21'h0A;
          d.one.hi = 21'h0A;
        end
        rpt_pkg::CH_LO_F: begin
          d.one.lo = 21'h0C;
          d.one.hi = 21'h0C;
        end
        rpt_pkg::CH_LO_R: begin
          d.one.lo = 21'h0D;
          d.one.hi = 21'h0D;
        end
        rpt_pkg::CH_LO_T: begin
          d.one.lo = 21'h09;
          d.one.hi = 21'h09;
        end
        rpt_pkg::CH_LO_V: begin
          d.one.lo = 21'h0B;
          d.one.hi = 21'h0B;
        end
        default: begin
          d.one.kind = rpt_pkg::KIND_ERR;
          d.one.lo   = '0;
          d.one.hi   = '0;
        end
      endcase
    end else begin
      unique case (c)
        rpt_pkg::CH_LPAR:  d.one.kind = rpt_pkg::KIND_OPEN;
        rpt_pkg::CH_RPAR:  d.one.kind = rpt_pkg::KIND_CLOSE;
        rpt_pkg::CH_STAR:  d.one.kind = rpt_pkg::KIND_STAR;
        rpt_pkg::CH_PLUS:  d.one.kind = rpt_pkg::KIND_PLUS;
        rpt_pkg::CH_QMARK: d.one.kind = rpt_pkg::KIND_OPT;
        rpt_pkg::CH_BAR:   d.one.kind = rpt_pkg::KIND_UNION;
        rpt_pkg::CH_DOT: begin
          d.one.lo = 21'h00;
          d.one.hi = 21'hFF;
        end
        rpt_pkg::CH_BSL: begin
          if (in_ch.is_last) begin
            d.one.kind = rpt_pkg::KIND_ERR;
            d.one.lo   = '0;
            d.one.hi   = '0;
          end else begin
            d.body  = rpt_pkg::BODY_NONE;
            esc_set = 1'b1;
          end
        end
        default: d.one.kind = rpt_pkg::KIND_SYM;
      endcase
    end
  end

  assign esc_nxt = in_xfer ? esc_set : esc_r;

  // a lone backslash produces no tokens and is not queued
  assign q_push = in_xfer && (d.body != rpt_pkg::BODY_NONE || d.has_end);
  assign q_desc = d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r <= 1'b0;
    end else begin
      esc_r <= esc_nxt;
    end
  end

  `ASSERT_NXT(a_last_clears_escape, clk, rst_n, in_xfer && in_ch.is_last, !esc_r)
  `ASSERT_IMP(a_escape_only_from_bsl, clk, rst_n, esc_set, !esc_r && c == rpt_pkg::CH_BSL)

endmodule

/* src/rpt_queue.sv */
`include "assert_macros.svh"

module rpt_queue #(
  parameter int DEPTH = rpt_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rpt_pkg::desc_t push_desc,
  output logic           push_ready,
  input  logic           pop,
  output rpt_pkg::desc_t head_desc,
  output logic           head_valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rpt_pkg::desc_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count_r != CNT_W'(DEPTH);
  assign head_valid = count_r != '0;
  assign head_desc  = mem[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_desc;
    end
  end

  `ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH))
  `ASSERT_IMP(a_pop_nonempty, clk, rst_n, pop, head_valid)

endmodule

/* src/rpt_back.sv */
`include "assert_macros.svh"

module rpt_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  rpt_pkg::desc_t q_desc,
  output logic           q_pop,
  rpt_out_if.source      out_ch
);

  rpt_pkg::pos_t  pos_r;
  rpt_pkg::pos_t  pos_nxt;
  rpt_pkg::pos_t  len;
  rpt_pkg::pos_t  total;
  rpt_pkg::tok_t  tok;
  logic           tok_last;
  logic           advance;

  logic           valid_r;
  rpt_pkg::kind_t kind_r;
  rpt_pkg::cp_t   lo_r;
  rpt_pkg::cp_t   hi_r;
  logic           last_r;

  assign len      = rpt_pkg::body_len(q_desc.body);
  assign total    = len + {3'd0, q_desc.has_end};
  assign tok_last = pos_r == total - 4'd1;
  assign advance  = q_valid && (!valid_r || out_ch.ready);
  assign q_pop    = advance && tok_last;

  always_comb begin
    if (pos_r < len) begin
      tok = rpt_pkg::body_tok(q_desc, pos_r);
    end else begin
      tok.kind = rpt_pkg::KIND_END;
      tok.lo   = '0;
      tok.hi   = '0;
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    if (advance) begin
      pos_nxt = tok_last ? '0 : pos_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      if (advance) begin
        valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      kind_r <= tok.kind;
      lo_r   <= tok.lo;
      hi_r   <= tok.hi;
      last_r <= tok_last;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.token_kind  = kind_r;
  assign out_ch.range_low   = lo_r;
  assign out_ch.range_high  = hi_r;
  assign out_ch.last_of_run = last_r;

  `ASSERT_IMP(a_pos_in_run, clk, rst_n, q_valid, pos_r < total)
  `ASSERT_NXT(a_run_restarts, clk, rst_n, q_pop, pos_r == '0)

endmodule

/* dv/regex_pattern_tokenizer_core_tb.sv */
`timescale 1ns / 100ps

module regex_pattern_tokenizer_core_tb;

  localparam int           IDLE_PCT    = 38;
  localparam int           STALL_LIMIT = 2000;
  localparam int           RAND_ITEMS  = 75;
  localparam rpt_pkg::cp_t CH_LO_Q     = 21'h71;

  localparam rpt_pkg::cp_t OPERATORS [7] = '{rpt_pkg::CH_LPAR, rpt_pkg::CH_RPAR,
                                             rpt_pkg::CH_STAR, rpt_pkg::CH_PLUS,
                                             rpt_pkg::CH_QMARK, rpt_pkg::CH_BAR,
                                             rpt_pkg::CH_DOT};
  localparam rpt_pkg::cp_t ESC_CHARS [19] = '{rpt_pkg::CH_LPAR, rpt_pkg::CH_RPAR,
                                              rpt_pkg::CH_STAR, rpt_pkg::CH_PLUS,
                                              rpt_pkg::CH_QMARK, rpt_pkg::CH_BAR,
                                              rpt_pkg::CH_BSL, rpt_pkg::CH_DOT,
                                              rpt_pkg::CH_LO_D, rpt_pkg::CH_UP_D,
                                              rpt_pkg::CH_LO_S, rpt_pkg::CH_UP_S,
                                              rpt_pkg::CH_LO_W, rpt_pkg::CH_UP_W,
                                              rpt_pkg::CH_LO_N, rpt_pkg::CH_LO_F,
                                              rpt_pkg::CH_LO_R, rpt_pkg::CH_LO_T,
                                              rpt_pkg::CH_LO_V};

  typedef struct {
    rpt_pkg::cp_t cp;
    logic         last;
    bit           drain;
  } pattern_char_t;

  typedef struct {
    rpt_pkg::tok_t tok;
    logic          run_end;
  } token_exp_t;

  logic clk;
  logic rst_n;

  rpt_in_if  in_ch ();
  rpt_out_if out_ch ();

  regex_pattern_tokenizer_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pattern_char_t to_send[$];
  token_exp_t    expected_tokens[$];
  logic          esc_armed;
  int            n_in = 0;
  int            n_out = 0;
  int            total_items = 0;
  int            mismatches = 0;
  int            quiet = 0;

  // both sides run flat out through this stretch
  wire steady = (n_in >= 45) && (n_in < 70);

  function automatic bit idle_now();
    return !steady && ($urandom_range(99) < IDLE_PCT);
  endfunction

  function automatic rpt_pkg::tok_t mk(input rpt_pkg::kind_t kind, input rpt_pkg::cp_t lo,
                                       input rpt_pkg::cp_t hi);
    rpt_pkg::tok_t t;
    t.kind = kind;
    t.lo   = lo;
    t.hi   = hi;
    return t;
  endfunction

  // bracketed union of n byte ranges, first range in the high bits
  function automatic void add_class(ref rpt_pkg::tok_t run[$], input int n,
                                    input logic [79:0] r);
    logic [15:0] rng;
    run.push_back(mk(rpt_pkg::KIND_OPEN, rpt_pkg::CH_LPAR, rpt_pkg::CH_LPAR));
    for (int k = 0; k < n; k++) begin
      if (k > 0) run.push_back(mk(rpt_pkg::KIND_UNION, rpt_pkg::CH_BAR, rpt_pkg::CH_BAR));
      rng = r[16*(n-1-k) +: 16];
      run.push_back(mk(rpt_pkg::KIND_SYM, {13'd0, rng[15:8]}, {13'd0, rng[7:0]}));
    end
    run.push_back(mk(rpt_pkg::KIND_CLOSE, rpt_pkg::CH_RPAR, rpt_pkg::CH_RPAR));
  endfunction

  function automatic void tokenize(input rpt_pkg::cp_t c, input logic last);
    rpt_pkg::tok_t run[$];
    token_exp_t    ent;
    if (esc_armed) begin
      esc_armed = 1'b0;
      case (c)
        rpt_pkg::CH_LPAR, rpt_pkg::CH_RPAR, rpt_pkg::CH_STAR, rpt_pkg::CH_PLUS,
        rpt_pkg::CH_QMARK, rpt_pkg::CH_BAR, rpt_pkg::CH_BSL, rpt_pkg::CH_DOT:
          run.push_back(mk(rpt_pkg::KIND_SYM, c, c));
        rpt_pkg::CH_LO_D: run.push_back(mk(rpt_pkg::KIND_SYM, 21'h30, 21'h39));
        rpt_pkg::CH_UP_D: add_class(run, 2, 80'({16'h002F, 16'h3AFF}));
        rpt_pkg::CH_LO_S: add_class(run, 2, 80'({16'h090D, 16'h2020}));
        rpt_pkg::CH_UP_S: add_class(run, 3, 80'({16'h0008, 16'h0E1F, 16'h21FF}));
        rpt_pkg::CH_LO_W: add_class(run, 4, 80'({16'h3039, 16'h415A, 16'h5F5F, 16'h617A}));
        rpt_pkg::CH_UP_W:
          add_class(run, 5, {16'h002F, 16'h3A40, 16'h5B5E, 16'h6060, 16'h7BFF});
        rpt_pkg::CH_LO_N: run.push_back(mk(rpt_pkg::KIND_SYM, 21'h0A, 21'h0A));
        rpt_pkg::CH_LO_F: run.push_back(mk(rpt_pkg::KIND_SYM, 21'h0C, 21'h0C));
        rpt_pkg::CH_LO_R: run.push_back(mk(rpt_pkg::KIND_SYM, 21'h0D, 21'h0D));
        rpt_pkg::CH_LO_T: run.push_back(mk(rpt_pkg::KIND_SYM, 21'h09, 21'h09));
        rpt_pkg::CH_LO_V: run.push_back(mk(rpt_pkg::KIND_SYM, 21'h0B, 21'h0B));
        default: run.push_back(mk(rpt_pkg::KIND_ERR, 21'd0, 21'd0));
      endcase
    end else begin
      case (c)
        rpt_pkg::CH_LPAR:  run.push_back(mk(rpt_pkg::KIND_OPEN, c, c));
        rpt_pkg::CH_RPAR:  run.push_back(mk(rpt_pkg::KIND_CLOSE, c, c));
        rpt_pkg::CH_STAR:  run.push_back(mk(rpt_pkg::KIND_STAR, c, c));
        rpt_pkg::CH_PLUS:  run.push_back(mk(rpt_pkg::KIND_PLUS, c, c));
        rpt_pkg::CH_QMARK: run.push_back(mk(rpt_pkg::KIND_OPT, c, c));
        rpt_pkg::CH_BAR:   run.push_back(mk(rpt_pkg::KIND_UNION, c, c));
        rpt_pkg::CH_DOT:   run.push_back(mk(rpt_pkg::KIND_SYM, 21'h00, 21'hFF));
        rpt_pkg::CH_BSL: begin
          if (last) run.push_back(mk(rpt_pkg::KIND_ERR, 21'd0, 21'd0));
          else      esc_armed = 1'b1;
        end
        default:  run.push_back(mk(rpt_pkg::KIND_SYM, c, c));
      endcase
    end
    if (last) begin
      esc_armed = 1'b0;
      run.push_back(mk(rpt_pkg::KIND_END, 21'd0, 21'd0));
    end
    foreach (run[k]) begin
      ent.tok     = run[k];
      ent.run_end = (k == run.size() - 1);
      expected_tokens.push_back(ent);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("tb: mismatch at token %0d: %s", n_out, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  task automatic add(input rpt_pkg::cp_t cp, input logic last, input bit drain = 1'b0);
    pattern_char_t p;
    p.cp    = cp;
    p.last  = last;
    p.drain = drain;
    to_send.push_back(p);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    pattern_char_t nxt;
    logic          holding;
    if (!rst_n) begin
      in_ch.valid      <= 1'b0;
      in_ch.code_point <= '0;
      in_ch.is_last    <= 1'b0;
      esc_armed = 1'b0;
    end else begin
      holding = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        tokenize(in_ch.code_point, in_ch.is_last);
        n_in <= n_in + 1;
        holding = 1'b0;
      end
      if (!holding) begin
        if (to_send.size() > 0 && !(to_send[0].drain && expected_tokens.size() > 0) &&
            !idle_now()) begin
          nxt = to_send[0];
          to_send.delete(0);
          in_ch.valid      <= 1'b1;
          in_ch.code_point <= nxt.cp;
          in_ch.is_last    <= nxt.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    token_exp_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !idle_now();
      if (out_ch.valid && out_ch.ready) begin
        if (expected_tokens.size() == 0) begin
          report_mismatch("token with nothing expected");
        end else begin
          want = expected_tokens[0];
          expected_tokens.delete(0);
          check_field("token_kind", 32'(out_ch.token_kind), 32'(want.tok.kind));
          check_field("range_low", 32'(out_ch.range_low), 32'(want.tok.lo));
          check_field("range_high", 32'(out_ch.range_high), 32'(want.tok.hi));
          check_field("last_of_run", 32'(out_ch.last_of_run), 32'(want.run_end));
        end
        n_out++;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int           n_rand;
    int           plen;
    int           sel;
    bit           lastp;
    bit           first_rand;
    rpt_pkg::cp_t c;

    rst_n = 1'b0;

    // operators, field extremes, class escapes, unknown and trailing escapes
    foreach (OPERATORS[k]) add(OPERATORS[k], 1'b0);
    add(21'h000000, 1'b0);
    add(21'h1FFFFF, 1'b0);
    add(21'h10FFFF, 1'b1);
    add(rpt_pkg::CH_BSL, 1'b0);
    add(rpt_pkg::CH_UP_W, 1'b0);
    add(rpt_pkg::CH_BSL, 1'b0);
    add(rpt_pkg::CH_UP_S, 1'b0);
    add(rpt_pkg::CH_BSL, 1'b0);
    add(CH_LO_Q, 1'b0);
    add(rpt_pkg::CH_BSL, 1'b0);
    add(rpt_pkg::CH_LO_W, 1'b1);
    add(rpt_pkg::CH_BSL, 1'b1);
    add(rpt_pkg::CH_BSL, 1'b0);
    add(rpt_pkg::CH_BSL, 1'b0);
    add(rpt_pkg::CH_DOT, 1'b1);
    add(rpt_pkg::CH_BSL, 1'b0);
    add(rpt_pkg::CH_UP_W, 1'b1);

    // random patterns, mostly well formed
    n_rand     = 0;
    first_rand = 1'b1;
    while (n_rand < RAND_ITEMS) begin
      plen = $urandom_range(8, 1);
      for (int i = 0; i < plen; i++) begin
        lastp = (i == plen - 1);
        sel   = $urandom_range(99);
        if (sel < 30) begin
          add(rpt_pkg::cp_t'($urandom_range(126, 32)), lastp, first_rand);
          n_rand++;
        end else if (sel < 50) begin
          add(OPERATORS[$urandom_range(6)], lastp, first_rand);
          n_rand++;
        end else if (sel < 85) begin
          if ($urandom_range(9) == 0) c = rpt_pkg::cp_t'($urandom);
          else                        c = ESC_CHARS[$urandom_range(18)];
          add(rpt_pkg::CH_BSL, 1'b0, first_rand);
          add(c, lastp);
          n_rand += 2;
        end else if (sel < 92 || !lastp) begin
          c = rpt_pkg::cp_t'($urandom);
          add(c, lastp, first_rand);
          n_rand++;
        end else begin
          add(rpt_pkg::CH_BSL, 1'b1, first_rand);
          n_rand++;
        end
        first_rand = 1'b0;
      end
    end
    total_items = to_send.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (n_in < total_items || expected_tokens.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/rpt_pkg.sv
src/rpt_channels.sv
src/rpt_front.sv
src/rpt_queue.sv
src/rpt_back.sv
src/regex_pattern_tokenizer_core.sv
dv/regex_pattern_tokenizer_core_tb.sv
